// ===== hdl/scan_disk_seek_order_unit_defines.svh =====
// Assertion macros for the disk seek order unit.
`ifndef SCAN_DISK_SEEK_ORDER_UNIT_DEFINES_SVH
`define SCAN_DISK_SEEK_ORDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Checks a property at every clock edge outside reset.
`define SDSO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sdso assertion failed");

// Checks that a condition is followed by another one in the next cycle.
`define SDSO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdso assertion failed");

`else

`define SDSO_ASSERT(lbl, prop)
`define SDSO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/sdso_pkg.sv =====
// Shared types and constants of the disk seek order unit.
package sdso_pkg;

    localparam int unsigned MAX_REQUESTS_DEF = 64;
    localparam int unsigned CYL_BITS_DEF     = 12;

    localparam int unsigned SEEK_W      = 13;
    localparam int unsigned ORDER_IDX_W = 6;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [SEEK_W-1:0] SEEK_MAX = 13'd8191;

    localparam logic [CFG_IDX_W-1:0] REG_START_CYLINDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP       = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SERVE_INIT,
        ST_SERVE
    } t_state;

    // Control that travels with one read of the request store during the sweep.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic ovf;
    } t_serve_ctl;

endpackage

// ===== hdl/sdso_seek_acc.sv =====
// Head movement accumulator and result registers of the disk seek order unit.
module sdso_seek_acc #(
    parameter int CYL_BITS = sdso_pkg::CYL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sdso_pkg::t_serve_ctl               i_ctl,
    input  logic [CYL_BITS-1:0]                i_cyl,
    input  logic [CYL_BITS-1:0]                i_start_cyl,
    output logic                               o_strobe,
    output logic [CYL_BITS-1:0]                o_serviced_cylinder,
    output logic [sdso_pkg::ORDER_IDX_W-1:0]   o_order_index,
    output logic [sdso_pkg::SEEK_W-1:0]        o_running_seek,
    output logic                               o_dropped_any,
    output logic                               o_last_result
);

    localparam int SUM_W = ((CYL_BITS > int'(sdso_pkg::SEEK_W)) ?
                            CYL_BITS : int'(sdso_pkg::SEEK_W)) + 1;

    logic [CYL_BITS-1:0]              r_head;
    logic [sdso_pkg::SEEK_W-1:0]      r_seek;
    logic [sdso_pkg::ORDER_IDX_W-1:0] r_index;

    logic [CYL_BITS-1:0]              head_cur;
    logic [sdso_pkg::SEEK_W-1:0]      seek_cur;
    logic [sdso_pkg::ORDER_IDX_W-1:0] index_cur;
    logic [CYL_BITS-1:0]              move;
    logic [SUM_W-1:0]                 sum;
    logic [sdso_pkg::SEEK_W-1:0]      seek_new;

    // The first request of a sweep starts from the configured cylinder.
    always_comb begin
        head_cur  = i_ctl.first ? i_start_cyl : r_head;
        seek_cur  = i_ctl.first ? '0 : r_seek;
        index_cur = i_ctl.first ? '0 : r_index;
        move      = (i_cyl >= head_cur) ? (i_cyl - head_cur) : (head_cur - i_cyl);
        sum       = SUM_W'(seek_cur) + SUM_W'(move);
        seek_new  = (sum > SUM_W'(sdso_pkg::SEEK_MAX)) ? sdso_pkg::SEEK_MAX
                                                        : sum[sdso_pkg::SEEK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_head              <= i_cyl;
            r_seek              <= seek_new;
            r_index             <= index_cur + 1'b1;
            o_serviced_cylinder <= i_cyl;
            o_order_index       <= index_cur;
            o_running_seek      <= seek_new;
            o_dropped_any       <= i_ctl.ovf;
            o_last_result       <= i_ctl.last;
        end
    end

endmodule

// ===== hdl/scan_disk_seek_order_unit.sv =====
// Top level of the elevator disk seek order unit: request store, sort and sweep control.
// A request is taken only while the unit is idle; a non-final one is put in order by shifting the
// larger entries up one place, is written directly when the store is empty, or is dropped when full.
// A final request then adds a scan of the store for the split at the start cylinder and a sweep of
// store reads; results follow one per cycle, each registered in the accumulator after its read.
// Reset (synchronous, active low) clears the control state; the store itself is not cleared.

`include "scan_disk_seek_order_unit_defines.svh"

module scan_disk_seek_order_unit #(
    parameter int MAX_REQUESTS = sdso_pkg::MAX_REQUESTS_DEF,
    parameter int CYL_BITS     = sdso_pkg::CYL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel.
    input  logic                               start,
    output logic                               busy,
    input  logic [CYL_BITS-1:0]                i_request_cylinder,
    input  logic                               i_final_request,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sdso_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sdso_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Result channel: one strobed result per served request.
    output logic                               o_strobe,
    output logic [CYL_BITS-1:0]                o_serviced_cylinder,
    output logic [sdso_pkg::ORDER_IDX_W-1:0]   o_order_index,
    output logic [sdso_pkg::SEEK_W-1:0]        o_running_seek,
    output logic                               o_dropped_any,
    output logic                               o_last_result
);

    // The count must hold the full depth, while a store address only needs the depth minus one.
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

    // Request store, kept in ascending order. Only entries below the count are ever read.
    logic [CYL_BITS-1:0] r_mem [MAX_REQUESTS];
    logic [CYL_BITS-1:0] r_rdata;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [CYL_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    // Control state.
    sdso_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [CYL_BITS-1:0]  r_start_cyl, n_start_cyl;
    logic                 r_sweep_up, n_sweep_up;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic                 r_first, n_first;
    sdso_pkg::t_serve_ctl r_ctl, n_ctl;

    // Working registers of the current transaction.
    logic [CYL_BITS-1:0]  r_cyl, n_cyl;
    logic                 r_fin, n_fin;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic                 r_asc, n_asc;
    logic [CNT_W-1:0]     r_split, n_split;

    logic                 accept;
    logic [CNT_W-1:0]     ptr_ext;
    logic [CNT_W-1:0]     split_m1;

    assign busy        = (r_state != sdso_pkg::ST_IDLE);
    assign o_cfg_ready = !busy;
    assign accept      = start && !busy;
    assign ptr_ext     = CNT_W'(r_ptr);
    assign split_m1    = r_split - 1'b1;

    // Store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdso_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_start_cyl <= '0;
            r_sweep_up  <= 1'b1;
            r_rem       <= '0;
            r_first     <= 1'b0;
            r_ctl       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_start_cyl <= n_start_cyl;
            r_sweep_up  <= n_sweep_up;
            r_rem       <= n_rem;
            r_first     <= n_first;
            r_ctl       <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cyl   <= n_cyl;
        r_fin   <= n_fin;
        r_k     <= n_k;
        r_ptr   <= n_ptr;
        r_asc   <= n_asc;
        r_split <= n_split;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_start_cyl = r_start_cyl;
        n_sweep_up  = r_sweep_up;
        n_rem       = r_rem;
        n_first     = r_first;
        n_ctl       = '0;
        n_cyl       = r_cyl;
        n_fin       = r_fin;
        n_k         = r_k;
        n_ptr       = r_ptr;
        n_asc       = r_asc;
        n_split     = r_split;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_cyl;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        // Configuration is only written while the unit is idle; unknown indexes are ignored.
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sdso_pkg::REG_START_CYLINDER: n_start_cyl = i_cfg_data[CYL_BITS-1:0];
                sdso_pkg::REG_SWEEP_UP:       n_sweep_up  = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            sdso_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cyl = i_request_cylinder;
                    n_fin = i_final_request;
                    if (r_count == MAX_CNT) begin
                        // Store full: the request is dropped and the batch is flagged.
                        n_ovf   = 1'b1;
                        n_state = i_final_request ? sdso_pkg::ST_SCAN_RD : sdso_pkg::ST_IDLE;
                    end else if (r_count == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = i_request_cylinder;
                        n_count   = r_count + 1'b1;
                        n_state   = i_final_request ? sdso_pkg::ST_SCAN_RD : sdso_pkg::ST_IDLE;
                    end else begin
                        // Start the insertion walk at the top entry.
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(r_count - 1'b1);
                        n_k       = r_count;
                        n_state   = sdso_pkg::ST_INS_CMP;
                    end
                end
            end

            sdso_pkg::ST_INS_CMP: begin
                // r_rdata holds entry k-1. Larger entries move up by one place.
                mem_we    = 1'b1;
                mem_waddr = r_k[IDX_W-1:0];
                if (r_rdata > r_cyl) begin
                    mem_wdata = r_rdata;
                    n_k       = r_k - 1'b1;
                    if (r_k == CNT_W'(1)) begin
                        n_state = sdso_pkg::ST_INS_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(r_k - CNT_W'(2));
                    end
                end else begin
                    mem_wdata = r_cyl;
                    n_count   = r_count + 1'b1;
                    n_state   = r_fin ? sdso_pkg::ST_SCAN_RD : sdso_pkg::ST_IDLE;
                end
            end

            sdso_pkg::ST_INS_PUT: begin
                // The new request is the smallest so far.
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_cyl;
                n_count   = r_count + 1'b1;
                n_state   = r_fin ? sdso_pkg::ST_SCAN_RD : sdso_pkg::ST_IDLE;
            end

            sdso_pkg::ST_SCAN_RD: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_ptr     = '0;
                n_state   = sdso_pkg::ST_SCAN;
            end

            sdso_pkg::ST_SCAN: begin
                // Find the first entry at or above the start cylinder.
                if (r_rdata >= r_start_cyl) begin
                    n_split = ptr_ext;
                    n_state = sdso_pkg::ST_SERVE_INIT;
                end else if (ptr_ext + 1'b1 == r_count) begin
                    n_split = r_count;
                    n_state = sdso_pkg::ST_SERVE_INIT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr + 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end
            end

            sdso_pkg::ST_SERVE_INIT: begin
                n_rem   = r_count;
                n_first = 1'b1;
                n_state = sdso_pkg::ST_SERVE;
                if (r_sweep_up) begin
                    if (r_split < r_count) begin
                        n_ptr = r_split[IDX_W-1:0];
                        n_asc = 1'b1;
                    end else begin
                        n_ptr = split_m1[IDX_W-1:0];
                        n_asc = 1'b0;
                    end
                end else begin
                    if (r_split != '0) begin
                        n_ptr = split_m1[IDX_W-1:0];
                        n_asc = 1'b0;
                    end else begin
                        n_ptr = '0;
                        n_asc = 1'b1;
                    end
                end
            end

            sdso_pkg::ST_SERVE: begin
                // One read per cycle; the accumulator handles each one in the cycle after its read.
                if (r_rem != '0) begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_ptr;
                    n_rem       = r_rem - 1'b1;
                    n_first     = 1'b0;
                    n_ctl.valid = 1'b1;
                    n_ctl.first = r_first;
                    n_ctl.last  = (r_rem == CNT_W'(1));
                    n_ctl.ovf   = r_ovf;
                    // Walk one way and turn at the end of that half toward the other half.
                    if (r_asc) begin
                        if (ptr_ext + 1'b1 < r_count) begin
                            n_ptr = r_ptr + 1'b1;
                        end else begin
                            n_ptr = split_m1[IDX_W-1:0];
                            n_asc = 1'b0;
                        end
                    end else begin
                        if (r_ptr != '0) begin
                            n_ptr = r_ptr - 1'b1;
                        end else begin
                            n_ptr = r_split[IDX_W-1:0];
                            n_asc = 1'b1;
                        end
                    end
                end
                if (r_ctl.valid && r_ctl.last) begin
                    // The batch is done; the head position is kept in the accumulator.
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = sdso_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sdso_pkg::ST_IDLE;
            end
        endcase
    end

    sdso_seek_acc #(
        .CYL_BITS(CYL_BITS)
    ) u_seek_acc (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (r_ctl),
        .i_cyl               (r_rdata),
        .i_start_cyl         (r_start_cyl),
        .o_strobe            (o_strobe),
        .o_serviced_cylinder (o_serviced_cylinder),
        .o_order_index       (o_order_index),
        .o_running_seek      (o_running_seek),
        .o_dropped_any       (o_dropped_any),
        .o_last_result       (o_last_result)
    );

    // The store never holds more requests than its depth.
    `SDSO_ASSERT(a_count_bound, r_count <= MAX_CNT)
    // Store reads for the accumulator only happen during the sweep.
    `SDSO_ASSERT(a_ctl_in_serve, !r_ctl.valid || (r_state == sdso_pkg::ST_SERVE))
    // When the final result is shown, the batch has already been cleared.
    `SDSO_ASSERT(a_last_clears, !(o_strobe && o_last_result) || (r_count == '0 && !r_ovf))
    // Results of one sweep come in consecutive cycles with consecutive order indexes.
    `SDSO_ASSERT_NEXT(a_index_step, o_strobe && !o_last_result,
        o_strobe && (o_order_index == sdso_pkg::ORDER_IDX_W'($past(o_order_index) + 1'b1)))

endmodule
